// ----- rtl/lbfr_pkg.sv -----
// Package with the item codes, defaults and shared types of the bit-field reader.
package lbfr_pkg;

  // Default depth of the byte store.
  localparam int unsigned STORE_BYTES_DEF = 4096;

  // Item function codes.
  localparam logic [2:0] FUNC_CLEAR   = 3'd0;
  localparam logic [2:0] FUNC_APPEND  = 3'd1;
  localparam logic [2:0] FUNC_READ    = 3'd2;
  localparam logic [2:0] FUNC_VARUINT = 3'd3;
  localparam logic [2:0] FUNC_SKIP    = 3'd4;
  localparam logic [2:0] FUNC_SETPOS  = 3'd5;

  // Largest field a read-bits item may return.
  localparam logic [5:0] MAX_READ_BITS = 6'd32;

  // Slot index of the last byte of the longest varuint (five bytes).
  localparam logic [2:0] VARUINT_LAST_SLOT = 3'd4;

  // Control of the shared alignment unit.
  typedef struct packed {
    logic [2:0] off;     // bit offset of the field inside the first byte
    logic [2:0] slot;    // index of the aligned byte within the field
    logic       varint;  // pack seven payload bits per byte instead of eight
  } align_ctl_t;

endpackage

// ----- rtl/lbfr_if.sv -----
// Valid/ready channel interfaces for the reader's items and results.
interface lbfr_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [5:0]  width;
  logic [7:0]  byte_value;
  logic [15:0] amount;

  modport source (output valid, func, width, byte_value, amount, input ready);
  modport sink   (input valid, func, width, byte_value, amount, output ready);
endinterface

interface lbfr_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] value;
  logic        overflow;
  logic [15:0] position;

  modport source (output valid, value, overflow, position, input ready);
  modport sink   (input valid, value, overflow, position, output ready);
endinterface

// ----- rtl/lbfr_store.sv -----
// Byte store: one write port and one registered read port.
module lbfr_store #(
  parameter int unsigned STORE_BYTES = lbfr_pkg::STORE_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           we,
  input  logic [$clog2(STORE_BYTES)-1:0] waddr,
  input  logic [7:0]                     wdata,
  input  logic [$clog2(STORE_BYTES)-1:0] raddr,
  output logic [7:0]                     rdata
);
  import lbfr_pkg::*;

  logic [7:0] mem [STORE_BYTES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/lbfr_align.sv -----
// Shared alignment unit: pulls one byte at a bit offset from two stored bytes
// and merges it into the field accumulator.
module lbfr_align (
  input  lbfr_pkg::align_ctl_t ctl,
  input  logic [7:0]           lo_byte,
  input  logic [7:0]           hi_byte,
  input  logic [31:0]          acc,
  output logic [7:0]           aligned,
  output logic [31:0]          acc_next
);
  import lbfr_pkg::*;

  logic [15:0] pair;
  logic [5:0]  shamt;

  assign pair    = {hi_byte, lo_byte};
  assign aligned = 8'(pair >> ctl.off);

  // Eight bits per slot for raw fields, seven per slot for varuint payloads.
  always_comb begin
    if (ctl.varint) begin
      shamt    = {ctl.slot, 3'b000} - {3'b000, ctl.slot};
      acc_next = acc | (32'(aligned[6:0]) << shamt);
    end else begin
      shamt    = {ctl.slot, 3'b000};
      acc_next = acc | (32'(aligned) << shamt);
    end
  end

endmodule

// ----- rtl/lsb_first_bit_field_reader.sv -----
// Top level of the LSB-first bit-field reader with its item sequencer.
//
// The reader keeps a byte store that append transactions fill in order, and a
// bit cursor into the loaded bits, with bits taken least significant first in
// each byte. Every request transaction gives exactly one response transaction.
// Clear, append, skip, set-position, unused codes, zero-width reads and
// read-bits items refused up front finish without reading the store: the
// request is taken in idle and the item goes straight to the done state.
// Read-bits and varuint items stream bytes out of the store's read port one
// per cycle through one shared alignment unit, by way of the fill and step
// states. A new request is taken only once the block is back in idle, after
// the last item has left the done state. A finished result sits in a staging
// register until the response register is free, so the response side may
// stall freely. Any access past the loaded length, or an append to a full
// store, returns overflow with value zero and leaves the cursor where it was.
// The position field carries the low 16 bits of the cursor after the item.
module lsb_first_bit_field_reader #(
  parameter int unsigned STORE_BYTES = lbfr_pkg::STORE_BYTES_DEF
) (
  input logic       clk,
  input logic       rst,
  lbfr_req_if.sink  req,
  lbfr_rsp_if.source rsp
);
  import lbfr_pkg::*;

  localparam int unsigned AW    = $clog2(STORE_BYTES);
  localparam int unsigned BW    = $clog2(STORE_BYTES + 1);
  localparam int unsigned LB_W  = BW + 3;
  localparam int unsigned CMP_W = ((LB_W > 16) ? LB_W : 16) + 1;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_FILL = 4'b0010,
    ST_STEP = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t           state, state_next;
  logic [BW-1:0]    count, count_next;      // loaded bytes
  logic [LB_W-1:0]  cursor, cursor_next;
  logic [LB_W:0]    pos, pos_next;          // varuint read position
  logic [AW-1:0]    raddr, raddr_next;
  logic [2:0]       off, off_next;
  logic [2:0]       slot, slot_next;
  logic [1:0]       last_slot, last_slot_next;
  logic             varint, varint_next;
  logic [5:0]       nbits, nbits_next;
  logic [31:0]      acc, acc_next;
  logic [31:0]      res_value, res_value_next;
  logic             res_ovf, res_ovf_next;
  logic             rsp_valid, rsp_valid_next;
  logic [31:0]      rsp_value, rsp_value_next;
  logic             rsp_ovf, rsp_ovf_next;
  logic [15:0]      rsp_pos, rsp_pos_next;

  logic [LB_W-1:0]  loaded;
  logic             accept;
  logic             store_full;
  logic             store_we;
  logic [AW-1:0]    store_raddr;
  logic [7:0]       store_rdata;
  logic [7:0]       prev;
  align_ctl_t       actl;
  logic [7:0]       aligned;
  logic [31:0]      acc_merged;
  logic [CMP_W-1:0] read_end;
  logic [CMP_W-1:0] skip_end;
  logic [LB_W:0]    pos_plus8;
  logic [31:0]      read_mask;
  logic [5:0]       nbits_m1;

  assign loaded     = {count, 3'b000};
  assign accept     = req.valid && req.ready;
  assign req.ready  = (state == ST_IDLE);
  assign store_full = (count == BW'(STORE_BYTES));
  assign store_we   = accept && (req.func == FUNC_APPEND) && !store_full;

  // In idle the store is addressed by the cursor so the first byte of a read
  // is on its way in the cycle the request is accepted.
  assign store_raddr = (state == ST_IDLE) ? cursor[AW+2:3] : raddr;

  lbfr_store #(
    .STORE_BYTES(STORE_BYTES)
  ) u_store (
    .clk  (clk),
    .we   (store_we),
    .waddr(count[AW-1:0]),
    .wdata(req.byte_value),
    .raddr(store_raddr),
    .rdata(store_rdata)
  );

  assign actl.off    = off;
  assign actl.slot   = slot;
  assign actl.varint = varint;

  lbfr_align u_align (
    .ctl     (actl),
    .lo_byte (prev),
    .hi_byte (store_rdata),
    .acc     (acc),
    .aligned (aligned),
    .acc_next(acc_merged)
  );

  assign read_end  = CMP_W'(cursor) + CMP_W'(req.width);
  assign skip_end  = CMP_W'(cursor) + CMP_W'(req.amount);
  assign pos_plus8 = pos + (LB_W + 1)'(8);
  assign read_mask = 32'hFFFF_FFFF >> (MAX_READ_BITS - nbits);
  assign nbits_m1  = req.width - 6'd1;

  always_comb begin
    state_next     = state;
    count_next     = count;
    cursor_next    = cursor;
    pos_next       = pos;
    raddr_next     = raddr + AW'(1);
    off_next       = off;
    slot_next      = slot;
    last_slot_next = last_slot;
    varint_next    = varint;
    nbits_next     = nbits;
    acc_next       = acc;
    res_value_next = res_value;
    res_ovf_next   = res_ovf;
    rsp_valid_next = rsp_valid && !rsp.ready;
    rsp_value_next = rsp_value;
    rsp_ovf_next   = rsp_ovf;
    rsp_pos_next   = rsp_pos;

    case (state)
      ST_IDLE: begin
        raddr_next     = cursor[AW+2:3] + AW'(1);
        off_next       = cursor[2:0];
        slot_next      = 3'd0;
        acc_next       = '0;
        pos_next       = {1'b0, cursor};
        nbits_next     = req.width;
        last_slot_next = nbits_m1[4:3];
        res_value_next = '0;
        res_ovf_next   = 1'b0;
        if (accept) begin
          state_next = ST_DONE;
          case (req.func)
            FUNC_CLEAR: begin
              count_next  = '0;
              cursor_next = '0;
            end
            FUNC_APPEND: begin
              if (store_full) begin
                res_ovf_next = 1'b1;
              end else begin
                count_next = count + BW'(1);
              end
            end
            FUNC_READ: begin
              if (req.width > MAX_READ_BITS || read_end > CMP_W'(loaded)) begin
                res_ovf_next = 1'b1;
              end else if (req.width != 6'd0) begin
                varint_next = 1'b0;
                state_next  = ST_FILL;
              end
            end
            FUNC_VARUINT: begin
              varint_next = 1'b1;
              state_next  = ST_FILL;
            end
            FUNC_SKIP: begin
              if (skip_end > CMP_W'(loaded)) begin
                res_ovf_next = 1'b1;
              end else begin
                cursor_next = LB_W'(skip_end);
              end
            end
            FUNC_SETPOS: begin
              if (CMP_W'(req.amount) > CMP_W'(loaded)) begin
                res_ovf_next = 1'b1;
              end else begin
                cursor_next = LB_W'(req.amount);
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_FILL: begin
        // The first byte lands in prev; the second is being read.
        state_next = ST_STEP;
      end
      ST_STEP: begin
        acc_next  = acc_merged;
        slot_next = slot + 3'd1;
        if (varint) begin
          // Each varuint byte must lie wholly inside the loaded bits.
          if (pos_plus8 > {1'b0, loaded}) begin
            res_ovf_next = 1'b1;
            state_next   = ST_DONE;
          end else begin
            pos_next = pos_plus8;
            if (!aligned[7] || slot == VARUINT_LAST_SLOT) begin
              res_value_next = acc_merged;
              cursor_next    = LB_W'(pos_plus8);
              state_next     = ST_DONE;
            end
          end
        end else if (slot[1:0] == last_slot) begin
          res_value_next = acc_merged & read_mask;
          cursor_next    = cursor + LB_W'(nbits);
          state_next     = ST_DONE;
        end
      end
      ST_DONE: begin
        // Hand the staged result over once the response register is free.
        if (!rsp_valid || rsp.ready) begin
          rsp_valid_next = 1'b1;
          rsp_value_next = res_value;
          rsp_ovf_next   = res_ovf;
          rsp_pos_next   = 16'(cursor);
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      cursor    <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      cursor    <= cursor_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    prev      <= store_rdata;
    pos       <= pos_next;
    raddr     <= raddr_next;
    off       <= off_next;
    slot      <= slot_next;
    last_slot <= last_slot_next;
    varint    <= varint_next;
    nbits     <= nbits_next;
    acc       <= acc_next;
    res_value <= res_value_next;
    res_ovf   <= res_ovf_next;
    rsp_value <= rsp_value_next;
    rsp_ovf   <= rsp_ovf_next;
    rsp_pos   <= rsp_pos_next;
  end

  assign rsp.valid    = rsp_valid;
  assign rsp.value    = rsp_value;
  assign rsp.overflow = rsp_ovf;
  assign rsp.position = rsp_pos;

endmodule

// ----- test/tb_lsb_first_bit_field_reader.sv -----
// Self-checking testbench for the LSB-first bit-field reader.
module tb_lsb_first_bit_field_reader;
  timeunit 1ns;
  timeprecision 1ps;

  import lbfr_pkg::*;

  // The tests run with the default store depth.
  localparam int unsigned STORE_BYTES = STORE_BYTES_DEF;

  // Length of the long stream that takes the cursor far from the start.
  localparam int unsigned LONG_BYTES = 300;
  localparam int unsigned LONG_BITS  = LONG_BYTES * 8;

  // The two function codes the block treats as no-ops.
  localparam logic [2:0] FUNC_UNUSED_LO = 3'd6;
  localparam logic [2:0] FUNC_UNUSED_HI = 3'd7;

  // Only the first mismatches are printed; the rest are still counted.
  localparam int MAX_PRINTED = 200;

  // One request transaction and one response transaction, as the ports carry them.
  typedef struct packed {
    logic [2:0]  func;
    logic [5:0]  width;
    logic [7:0]  byte_value;
    logic [15:0] amount;
  } item_t;

  typedef struct packed {
    logic [31:0] value;
    logic        overflow;
    logic [15:0] position;
  } result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  lbfr_req_if req_ch ();
  lbfr_rsp_if rsp_ch ();

  lsb_first_bit_field_reader #(
    .STORE_BYTES(STORE_BYTES)
  ) uut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  // 50 MHz clock: 10 ns high, 10 ns low.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow copy of the reader's state. It advances once per accepted request
  // transaction, in acceptance order, so it always matches what the block
  // should hold after the last accepted item.
  logic [7:0]  shadow_store [STORE_BYTES];
  int unsigned shadow_loaded = 0;
  int unsigned shadow_cursor = 0;

  // Responses predicted for accepted requests and not yet seen on the output.
  result_t pending_results [$];

  int error_count = 0;
  int checked_count = 0;

  // Idling control. idle_pct sets how often the sender pauses before an item
  // and how often the receiver starts a stall burst. hold_cycles, when set by
  // a test, makes the receiver refuse responses while it counts down.
  int idle_pct = 0;
  int hold_cycles = 0;
  int stall_left = 0;

  task automatic report_mismatch(input string what);
    if (error_count < MAX_PRINTED)
      $display("MISMATCH at %0t: %s", $realtime, what);
    error_count++;
  endtask

  // Collects count bits starting at bit position start, least significant
  // bit first within each byte; the first bit lands in bit 0 of the field.
  function automatic logic [31:0] gather_bits(input int unsigned start,
                                              input int unsigned count);
    logic [31:0] field;
    int unsigned p;
    field = '0;
    for (int unsigned i = 0; i < count; i++) begin
      p = start + i;
      field[i] = shadow_store[p >> 3][p & 7];
    end
    return field;
  endfunction

  // Works out the response to one request and applies its effect to the
  // shadow state. Refused items leave the cursor where it was and return a
  // zero value with the overflow flag set.
  function automatic result_t compute_reader_result(input item_t it);
    result_t r;
    int unsigned p;
    logic [7:0] b;
    bit ok;
    r = '0;
    case (it.func)
      FUNC_CLEAR: begin
        // The stored bytes survive a clear; only the length and cursor reset.
        shadow_loaded = 0;
        shadow_cursor = 0;
      end
      FUNC_APPEND: begin
        if ((shadow_loaded >> 3) >= STORE_BYTES) begin
          r.overflow = 1'b1;
        end else begin
          shadow_store[shadow_loaded >> 3] = it.byte_value;
          shadow_loaded += 8;
        end
      end
      FUNC_READ: begin
        if (it.width > MAX_READ_BITS || shadow_cursor + it.width > shadow_loaded) begin
          r.overflow = 1'b1;
        end else begin
          r.value = gather_bits(shadow_cursor, it.width);
          shadow_cursor += it.width;
        end
      end
      FUNC_VARUINT: begin
        // LEB128: seven payload bits per byte, stop after the first byte with
        // a clear top bit, at most five bytes. The fifth payload is shifted by
        // 28 and its upper bits fall off the 32-bit value.
        p = shadow_cursor;
        ok = 1'b1;
        for (int i = 0; i <= VARUINT_LAST_SLOT; i++) begin
          if (p + 8 > shadow_loaded) begin
            ok = 1'b0;
            break;
          end
          b = 8'(gather_bits(p, 8));
          p += 8;
          r.value = r.value | (32'(b[6:0]) << (7 * i));
          if (!b[7])
            break;
        end
        if (ok) begin
          shadow_cursor = p;
        end else begin
          r.value = '0;
          r.overflow = 1'b1;
        end
      end
      FUNC_SKIP: begin
        if (shadow_cursor + it.amount > shadow_loaded)
          r.overflow = 1'b1;
        else
          shadow_cursor += it.amount;
      end
      FUNC_SETPOS: begin
        // A position equal to the loaded length is legal: it marks the end.
        if (it.amount > shadow_loaded)
          r.overflow = 1'b1;
        else
          shadow_cursor = it.amount;
      end
      default: begin
      end
    endcase
    r.position = 16'(shadow_cursor);
    return r;
  endfunction

  // Offers one request transaction and returns at the edge that accepts it.
  // Valid stays high afterwards, so back-to-back items never lower and raise
  // it within one time step; it only drops when a gap is taken or the
  // pipeline is drained.
  task automatic send_item(input logic [2:0] func, input logic [5:0] width,
                           input logic [7:0] byte_value, input logic [15:0] amount);
    item_t it;
    int gap;
    it = '{func: func, width: width, byte_value: byte_value, amount: amount};
    if (idle_pct > 0 && $urandom_range(1, 100) <= idle_pct) begin
      gap = $urandom_range(1, 10);
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.func       <= it.func;
    req_ch.width      <= it.width;
    req_ch.byte_value <= it.byte_value;
    req_ch.amount     <= it.amount;
    do @(posedge clk); while (!req_ch.ready);
    pending_results.push_back(compute_reader_result(it));
  endtask

  // Stops offering and waits until every predicted response has come back.
  task automatic drain_results();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // Don't-care fields are randomized so every input bit toggles.
  function automatic logic [5:0] any_width();
    return 6'($urandom);
  endfunction

  function automatic logic [7:0] any_byte();
    return 8'($urandom);
  endfunction

  function automatic logic [15:0] any_amount();
    return 16'($urandom);
  endfunction

  // Directed checks on an empty stream and on a short known stream: every
  // function code, widths past 32, a five-byte varuint whose last payload is
  // truncated, a varuint that runs off the end, moves to the exact end and
  // past it, and a clear that keeps the stored bytes.
  task automatic test_directed_items();
    idle_pct = 25;
    // Empty stream: only zero-length accesses succeed.
    send_item(FUNC_READ, 6'd0, 8'h00, 16'h0000);
    send_item(FUNC_READ, 6'd1, 8'hFF, 16'hFFFF);
    send_item(FUNC_VARUINT, 6'd0, 8'h00, 16'h0000);
    send_item(FUNC_SETPOS, 6'd63, 8'h00, 16'h0000);
    send_item(FUNC_UNUSED_LO, 6'd63, 8'hFF, 16'hFFFF);
    send_item(FUNC_UNUSED_HI, 6'd0, 8'h00, 16'h0000);
    // Bytes FF 80 80 80 FF form a five-byte varuint; 00 5A A5 follow.
    send_item(FUNC_APPEND, 6'd0, 8'hFF, 16'h0000);
    send_item(FUNC_APPEND, 6'd0, 8'h80, 16'h0000);
    send_item(FUNC_APPEND, 6'd0, 8'h80, 16'h0000);
    send_item(FUNC_APPEND, 6'd0, 8'h80, 16'h0000);
    send_item(FUNC_APPEND, 6'd0, 8'hFF, 16'h0000);
    send_item(FUNC_APPEND, 6'd0, 8'h00, 16'h0000);
    send_item(FUNC_APPEND, 6'd0, 8'h5A, 16'h0000);
    send_item(FUNC_APPEND, 6'd0, 8'hA5, 16'h0000);
    send_item(FUNC_READ, 6'd63, 8'h00, 16'h0000);
    send_item(FUNC_VARUINT, 6'd0, 8'h00, 16'h0000);
    // A full 32-bit field that starts mid-byte and spans five bytes.
    send_item(FUNC_SETPOS, 6'd0, 8'h00, 16'd3);
    send_item(FUNC_READ, 6'd32, 8'h00, 16'h0000);
    send_item(FUNC_SKIP, 6'd0, 8'h00, 16'd29);
    send_item(FUNC_READ, 6'd0, 8'h00, 16'h0000);
    send_item(FUNC_READ, 6'd1, 8'h00, 16'h0000);
    send_item(FUNC_SKIP, 6'd0, 8'h00, 16'hFFFF);
    send_item(FUNC_SETPOS, 6'd0, 8'h00, 16'd64);
    // After a clear the old bytes remain but are out of reach until reloaded.
    send_item(FUNC_CLEAR, 6'd63, 8'hFF, 16'hFFFF);
    send_item(FUNC_APPEND, 6'd0, 8'h80, 16'h0000);
    send_item(FUNC_VARUINT, 6'd0, 8'h00, 16'h0000);
    send_item(FUNC_APPEND, 6'd0, 8'h01, 16'h0000);
    send_item(FUNC_VARUINT, 6'd0, 8'h00, 16'h0000);
  endtask

  // Loads a long stream and works right at its end, where reads, varuints,
  // skips and jumps reach the loaded length or just pass it.
  task automatic test_long_stream();
    idle_pct = 10;
    send_item(FUNC_CLEAR, any_width(), any_byte(), any_amount());
    for (int i = 0; i < LONG_BYTES; i++)
      send_item(FUNC_APPEND, any_width(), any_byte(), any_amount());
    send_item(FUNC_SETPOS, any_width(), any_byte(), 16'(LONG_BITS));
    send_item(FUNC_READ, 6'd0, any_byte(), any_amount());
    send_item(FUNC_READ, 6'd1, any_byte(), any_amount());
    send_item(FUNC_VARUINT, any_width(), any_byte(), any_amount());
    send_item(FUNC_SETPOS, any_width(), any_byte(), 16'(LONG_BITS - 32));
    send_item(FUNC_READ, 6'd32, any_byte(), any_amount());
    send_item(FUNC_SETPOS, any_width(), any_byte(), 16'(LONG_BITS - 8));
    send_item(FUNC_VARUINT, any_width(), any_byte(), any_amount());
    send_item(FUNC_SETPOS, any_width(), any_byte(), 16'(LONG_BITS + 1));
    send_item(FUNC_SETPOS, any_width(), any_byte(), 16'd0);
    send_item(FUNC_SKIP, any_width(), any_byte(), 16'(LONG_BITS));
    send_item(FUNC_SKIP, any_width(), any_byte(), 16'd1);
  endtask

  // The receiver refuses responses for a long stretch while the sender keeps
  // offering reads, so the staging and response registers fill up and the
  // block has to hold off its request side.
  task automatic test_output_backpressure();
    idle_pct = 0;
    send_item(FUNC_CLEAR, any_width(), any_byte(), any_amount());
    for (int i = 0; i < 16; i++)
      send_item(FUNC_APPEND, any_width(), any_byte(), any_amount());
    hold_cycles = 200;
    for (int i = 0; i < 40; i++) begin
      if (i % 3 == 0)
        send_item(FUNC_VARUINT, any_width(), any_byte(), any_amount());
      else
        send_item(FUNC_READ, 6'($urandom_range(0, 12)), any_byte(), any_amount());
    end
    idle_pct = 20;
  endtask

  // Random streams. Each one starts with a clear, loads a handful of bytes
  // (now and then a long run), either as raw bytes or as a chain of LEB128
  // encodings with random payloads, and then walks through it with a mix of
  // reads, varuints, skips and jumps. Short streams make the end of the data
  // come up often; out-of-range moves, wide reads, late appends and no-op
  // codes are mixed in as noise. No-op codes do not count toward the budget.
  task automatic test_random_streams(input int item_budget, input int idle_level);
    int sent;
    int nbytes;
    int nops;
    int vlen;
    int vleft;
    int pick;
    int unsigned span;
    bit as_varints;
    logic [7:0] b;
    sent = 0;
    while (sent < item_budget) begin
      // Some streams run with no idling at all on either side.
      idle_pct = ($urandom_range(0, 3) == 0) ? 0 : idle_level;
      send_item(FUNC_CLEAR, any_width(), any_byte(), any_amount());
      sent++;

      nbytes = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 200) : $urandom_range(1, 24);
      as_varints = 1'($urandom_range(0, 1));
      vlen = 0;
      vleft = 0;
      for (int i = 0; i < nbytes; i++) begin
        b = any_byte();
        if (as_varints) begin
          if (vleft == 0) begin
            vlen = $urandom_range(1, 5);
            vleft = vlen;
          end
          // Continuation bit on all but the last byte; a fifth byte may carry
          // either top bit, since decoding stops there anyway.
          if (vleft > 1)
            b[7] = 1'b1;
          else if (vlen != 5)
            b[7] = 1'b0;
          vleft--;
        end
        send_item(FUNC_APPEND, any_width(), b, any_amount());
        sent++;
      end

      nops = $urandom_range(4, 30);
      for (int i = 0; i < nops && sent < item_budget; i++) begin
        pick = $urandom_range(0, 99);
        span = shadow_loaded - shadow_cursor + 8;
        if (pick < (as_varints ? 20 : 45)) begin
          send_item(FUNC_READ,
                    ($urandom_range(0, 19) == 0) ? 6'($urandom_range(33, 63))
                                                 : 6'($urandom_range(0, 32)),
                    any_byte(), any_amount());
        end else if (pick < 68) begin
          send_item(FUNC_VARUINT, any_width(), any_byte(), any_amount());
        end else if (pick < 78) begin
          send_item(FUNC_SKIP, any_width(), any_byte(),
                    ($urandom_range(0, 9) == 0) ? any_amount()
                                                : 16'($urandom_range(0, span)));
        end else if (pick < 88) begin
          send_item(FUNC_SETPOS, any_width(), any_byte(),
                    ($urandom_range(0, 9) == 0) ? any_amount()
                                                : 16'($urandom_range(0, shadow_loaded + 8)));
        end else if (pick < 95) begin
          send_item(FUNC_APPEND, any_width(), any_byte(), any_amount());
        end else begin
          send_item($urandom_range(0, 1) ? FUNC_UNUSED_HI : FUNC_UNUSED_LO,
                    any_width(), any_byte(), any_amount());
          sent--;
        end
        sent++;
      end
    end
  endtask

  // Response side: ready follows the idling control. A hold-off asked for by
  // a test takes precedence and is counted down here, one per cycle.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles--;
      rsp_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      rsp_ch.ready <= 1'b0;
    end else if (idle_pct > 0 && $urandom_range(1, 400) <= idle_pct) begin
      // This cycle opens the burst, and stall_left holds how much of it remains.
      stall_left = $urandom_range(0, 9);
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  // Every accepted response transaction is matched, field by field, against
  // the oldest prediction still waiting.
  always @(posedge clk) begin : check_responses
    result_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      checked_count++;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("response %0d arrived with nothing pending", checked_count));
      end else begin
        want = pending_results.pop_front();
        if (rsp_ch.value !== want.value)
          report_mismatch($sformatf("response %0d value %h, expected %h",
                                    checked_count, rsp_ch.value, want.value));
        if (rsp_ch.overflow !== want.overflow)
          report_mismatch($sformatf("response %0d overflow %b, expected %b",
                                    checked_count, rsp_ch.overflow, want.overflow));
        if (rsp_ch.position !== want.position)
          report_mismatch($sformatf("response %0d position %0d, expected %0d",
                                    checked_count, rsp_ch.position, want.position));
      end
    end
  end

  // Test sequence. Reset is held at the start, the tests run in turn, and
  // the last stretch of random traffic runs with no idling. After the final
  // response the block gets a short quiet period in which any stray response
  // would still be caught.
  initial begin
    req_ch.valid      <= 1'b0;
    req_ch.func       <= FUNC_CLEAR;
    req_ch.width      <= '0;
    req_ch.byte_value <= '0;
    req_ch.amount     <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_directed_items();
    test_long_stream();
    test_output_backpressure();
    test_random_streams(1050, 35);
    test_random_streams(300, 0);

    drain_results();
    repeat (20) @(posedge clk);
    if (error_count == 0)
      $display("[lsb_first_bit_field_reader] OK");
    else
      $display("[lsb_first_bit_field_reader] ERROR");
    $finish;
  end

  // Watchdog: a correct run finishes in well under a tenth of this time.
  initial begin
    #40_000_000;
    $display("Timeout with %0d responses still pending", pending_results.size());
    $display("[lsb_first_bit_field_reader] ERROR");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/lbfr_pkg.sv
rtl/lbfr_if.sv
rtl/lbfr_store.sv
rtl/lbfr_align.sv
rtl/lsb_first_bit_field_reader.sv
test/tb_lsb_first_bit_field_reader.sv
